[rtl/gbr_pkg.sv]
// shared types, constants and kernel weight functions for the gaussian blur core
`default_nettype none

package gbr_pkg;

  // pixel packing: red in the low byte, blue in the high byte
  localparam int PIX_W = 24;
  localparam int CH_W = 8;
  localparam int NUM_CH = 3;

  // configuration port
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 8'd1;
  localparam logic [CFG_DATA_W-1:0] RESET_IMAGE_WIDTH = 12'd640;
  localparam logic [CFG_DATA_W-1:0] RESET_IMAGE_HEIGHT = 12'd480;

  // rows need room for the image height plus the flush rows
  localparam int ROW_W = 13;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_LEVEL_W = $clog2(QUEUE_DEPTH + 1);

  // gaussian normalization 1/(2*pi*sigma^2) in q0.24
  localparam logic [63:0] NORM_Q24 = 64'd427228;

  // per-item control that travels with the column
  typedef struct packed {
    logic out_due;
    logic last;
  } gbr_flags_t;

  // exp(-a*a/(2*sigma^2)) in q0.24
  function automatic logic [63:0] exp_q24(input int a);
    logic [63:0] v;
    case (a)
      0:       v = 64'd16777216;
      1:       v = 64'd15487322;
      2:       v = 64'd12182759;
      3:       v = 64'd8166348;
      4:       v = 64'd4664692;
      5:       v = 64'd2270549;
      6:       v = 64'd941785;
      7:       v = 64'd332878;
      8:       v = 64'd100261;
      9:       v = 64'd25733;
      10:      v = 64'd5628;
      11:      v = 64'd1049;
      12:      v = 64'd167;
      13:      v = 64'd23;
      14:      v = 64'd3;
      default: v = 64'd0;
    endcase
    return v;
  endfunction

  // weight of one tap at offset (dx, dy), frac fraction bits
  function automatic logic [63:0] tap_weight(input int dx, input int dy, input int frac);
    int a;
    int b;
    logic [63:0] t;
    a = (dx < 0) ? -dx : dx;
    b = (dy < 0) ? -dy : dy;
    if (a > 15) a = 15;
    if (b > 15) b = 15;
    t = (exp_q24(a) * exp_q24(b) + (64'd1 << 23)) >> 24;
    return (NORM_Q24 * t + (64'd1 << (47 - frac))) >> (48 - frac);
  endfunction

endpackage

`default_nettype wire

[rtl/gbr_ram.sv]
// generic single write port ram with registered read
`default_nettype none

module gbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

[rtl/gbr_front.sv]
// front end: config registers, raster counters, line store and column assembly
`default_nettype none

module gbr_front import gbr_pkg::*; #(
  parameter int MAX_WIDTH = 2048,
  parameter int KERNEL_SIZE = 15
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [CH_W-1:0]               in_red,
  input  wire logic [CH_W-1:0]               in_green,
  input  wire logic [CH_W-1:0]               in_blue,
  input  wire logic                          cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data,
  input  wire logic [QUEUE_LEVEL_W-1:0]      queue_level,
  output logic                               push,
  output gbr_flags_t                         push_flags,
  output logic [KERNEL_SIZE-1:0]             push_rowv,
  output logic [KERNEL_SIZE-1:0]             push_colv,
  output logic [KERNEL_SIZE*PIX_W-1:0]       push_column
);

  localparam int HALF = KERNEL_SIZE / 2;
  localparam int STACK = KERNEL_SIZE - 1;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = $clog2(MAX_WIDTH + 1);
  localparam int LEAD_MAX = HALF * MAX_WIDTH + HALF;
  localparam int LW = $clog2(LEAD_MAX + 1);
  localparam int SUMW = QUEUE_LEVEL_W + 1;
  localparam int STW = STACK * PIX_W;

  logic [CFG_DATA_W-1:0] image_width;
  logic [CFG_DATA_W-1:0] image_height;
  logic [EW-1:0]         eff_w;
  logic [CFG_DATA_W-1:0] eff_h;
  logic [LW-1:0]         lead_target;

  logic [CW-1:0]         col;
  logic [ROW_W-1:0]      row;
  logic [LW-1:0]         lead;
  logic [CW-1:0]         ox;
  logic [CFG_DATA_W-1:0] oy;

  logic                  accept;
  logic                  cfg_hit;
  logic                  out_due;
  logic                  last;
  logic                  col_wrap;
  logic                  ox_wrap;
  logic [PIX_W-1:0]      pixel;
  logic [KERNEL_SIZE-1:0] rowv;
  logic [KERNEL_SIZE-1:0] colv;

  logic                  f1_valid;
  logic [CW-1:0]         f1_col;
  logic [PIX_W-1:0]      f1_pixel;
  gbr_flags_t            f1_flags;
  logic [KERNEL_SIZE-1:0] f1_rowv;
  logic [KERNEL_SIZE-1:0] f1_colv;
  logic                  f1_fwd;
  logic [STW-1:0]        fwd_stack;
  logic [STW-1:0]        ram_rd;
  logic [STW-1:0]        old_stack;
  logic [STW-1:0]        new_stack;

  // effective image size
  always_comb begin
    if (image_width == '0) begin
      eff_w = EW'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(image_width);
    end
    eff_h = (image_height == '0) ? CFG_DATA_W'(1) : image_height;
    lead_target = LW'(LW'(HALF) * LW'(eff_w) + LW'(HALF));
  end

  // input handshake leaves room for the item in the column stage
  assign in_stall = ({1'b0, queue_level} + SUMW'(f1_valid)) >= SUMW'(QUEUE_DEPTH);
  assign accept = in_valid && !in_stall;
  assign cfg_hit = cfg_valid && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

  // classify the item
  always_comb begin
    out_due = (lead == lead_target);
    last = out_due && (EW'(ox) == eff_w - EW'(1)) && (oy == eff_h - CFG_DATA_W'(1));
    col_wrap = (EW'(col) + EW'(1)) >= eff_w;
    ox_wrap = (EW'(ox) + EW'(1)) >= eff_w;
    pixel = (row < {1'b0, eff_h}) ? {in_blue, in_green, in_red} : '0;
  end

  // padding masks for the output centered at (ox, oy)
  always_comb begin
    int t;
    for (int k = 0; k < KERNEL_SIZE; k++) begin
      t = int'(oy) + k - (KERNEL_SIZE - 1) + HALF;
      rowv[k] = (t >= 0) && (t < int'(eff_h));
      t = int'(ox) + k - (KERNEL_SIZE - 1) + HALF;
      colv[k] = (t >= 0) && (t < int'(eff_w));
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= RESET_IMAGE_WIDTH;
      image_height <= RESET_IMAGE_HEIGHT;
    end else if (cfg_valid) begin
      if (cfg_index == REG_IMAGE_WIDTH) begin
        image_width <= cfg_data;
      end
      if (cfg_index == REG_IMAGE_HEIGHT) begin
        image_height <= cfg_data;
      end
    end
  end

  // raster and output position counters
  always_ff @(posedge clk) begin
    if (rst || cfg_hit || (accept && last)) begin
      col <= '0;
      row <= '0;
      lead <= '0;
      ox <= '0;
      oy <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        col <= '0;
        row <= row + ROW_W'(1);
      end else begin
        col <= col + CW'(1);
      end
      if (!out_due) begin
        lead <= lead + LW'(1);
      end else if (ox_wrap) begin
        ox <= '0;
        oy <= oy + CFG_DATA_W'(1);
      end else begin
        ox <= ox + CW'(1);
      end
    end
  end

  // line store: one row of stacked pixels per column
  gbr_ram #(
    .WIDTH(STW),
    .DEPTH(MAX_WIDTH)
  ) u_line_store (
    .clk    (clk),
    .wr_en  (f1_valid),
    .wr_addr(f1_col),
    .wr_data(new_stack),
    .rd_en  (accept),
    .rd_addr(col),
    .rd_data(ram_rd)
  );

  // column stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else begin
      f1_valid <= accept;
    end
  end

  // column stage payload, forward when the previous item wrote the same column
  always_ff @(posedge clk) begin
    if (accept) begin
      f1_col <= col;
      f1_pixel <= pixel;
      f1_flags <= '{out_due: out_due, last: last};
      f1_rowv <= rowv;
      f1_colv <= colv;
      f1_fwd <= f1_valid && (f1_col == col);
    end
    if (f1_valid) begin
      fwd_stack <= new_stack;
    end
  end

  // assemble the window column and the shifted stack
  assign old_stack = f1_fwd ? fwd_stack : ram_rd;
  assign new_stack = {f1_pixel, old_stack[STW-1:PIX_W]};

  assign push = f1_valid;
  assign push_flags = f1_flags;
  assign push_rowv = f1_rowv;
  assign push_colv = f1_colv;
  assign push_column = {f1_pixel, old_stack};

endmodule

`default_nettype wire

[rtl/gbr_queue.sv]
// short register queue between front and back
`default_nettype none

module gbr_queue import gbr_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     push,
  input  wire logic [WIDTH-1:0]         push_data,
  input  wire logic                     pop,
  output logic                          head_valid,
  output logic [WIDTH-1:0]              head_data,
  output logic [QUEUE_LEVEL_W-1:0]      level
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] mem [QUEUE_DEPTH];
  logic [PW-1:0]    wp;
  logic [PW-1:0]    rp;
  logic             do_pop;

  assign head_valid = (level != '0);
  assign head_data = mem[rp];
  assign do_pop = pop && head_valid;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      level <= '0;
    end else begin
      if (push) begin
        wp <= (32'(wp) == QUEUE_DEPTH - 1) ? '0 : wp + PW'(1);
      end
      if (do_pop) begin
        rp <= (32'(rp) == QUEUE_DEPTH - 1) ? '0 : rp + PW'(1);
      end
      level <= level + QUEUE_LEVEL_W'(push) - QUEUE_LEVEL_W'(do_pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_data;
    end
  end

endmodule

`default_nettype wire

[rtl/gbr_back.sv]
// back end: window registers, weighted products, adder tree and output register
`default_nettype none

module gbr_back import gbr_pkg::*; #(
  parameter int KERNEL_SIZE = 15,
  parameter int COEF_FRAC_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          head_valid,
  input  wire gbr_flags_t                    head_flags,
  input  wire logic [KERNEL_SIZE-1:0]        head_rowv,
  input  wire logic [KERNEL_SIZE-1:0]        head_colv,
  input  wire logic [KERNEL_SIZE*PIX_W-1:0]  head_column,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [CH_W-1:0]                    out_red,
  output logic [CH_W-1:0]                    out_green,
  output logic [CH_W-1:0]                    out_blue,
  output logic                               last_of_frame
);

  localparam int K = KERNEL_SIZE;
  localparam int HALF = K / 2;
  localparam int WW = COEF_FRAC_BITS - 5;
  localparam int PW = WW + CH_W;
  localparam int SW = COEF_FRAC_BITS + 11;
  localparam int NG = (K + 7) / 8;
  localparam int RW = SW - COEF_FRAC_BITS;

  logic en;

  logic [PIX_W-1:0] win [K][K];
  logic             s0_valid;
  logic             s0_last;
  logic [K-1:0]     s0_rowv;
  logic [K-1:0]     s0_colv;

  logic [PW-1:0]    prod [NUM_CH][K][K];
  logic             p_valid;
  logic             p_last;

  logic [SW-1:0]    grp_next [NUM_CH][K][NG];
  logic [SW-1:0]    grp [NUM_CH][K][NG];
  logic             a_valid;
  logic             a_last;

  logic [SW-1:0]    rsum_next [NUM_CH][K];
  logic [SW-1:0]    rsum [NUM_CH][K];
  logic             b_valid;
  logic             b_last;

  logic [SW-1:0]    csum_next [NUM_CH][NG];
  logic [SW-1:0]    csum [NUM_CH][NG];
  logic             c_valid;
  logic             c_last;

  logic [SW-1:0]    total [NUM_CH];
  logic [CH_W-1:0]  clamped [NUM_CH];

  // whole pipeline moves unless a result waits
  assign en = !out_valid || !out_stall;
  assign pop = en && head_valid;

  // window shifts left by one column per item
  always_ff @(posedge clk) begin
    if (pop) begin
      for (int ky = 0; ky < K; ky++) begin
        for (int kx = 0; kx < K - 1; kx++) begin
          win[ky][kx] <= win[ky][kx + 1];
        end
        win[ky][K - 1] <= head_column[ky*PIX_W +: PIX_W];
      end
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      p_valid <= 1'b0;
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= head_valid && head_flags.out_due;
      p_valid <= s0_valid;
      a_valid <= p_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
      out_valid <= c_valid;
    end
  end

  // side data along the chain
  always_ff @(posedge clk) begin
    if (en) begin
      s0_last <= head_flags.last;
      s0_rowv <= head_rowv;
      s0_colv <= head_colv;
      p_last <= s0_last;
      a_last <= p_last;
      b_last <= a_last;
      c_last <= b_last;
      last_of_frame <= c_last;
    end
  end

  // masked products with constant weights
  always_ff @(posedge clk) begin
    if (en) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        for (int ky = 0; ky < K; ky++) begin
          for (int kx = 0; kx < K; kx++) begin
            if (s0_rowv[ky] && s0_colv[kx]) begin
              prod[ch][ky][kx] <= PW'(win[ky][kx][ch*CH_W +: CH_W]) *
                                  PW'(tap_weight(kx - (K - 1) + HALF, ky - (K - 1) + HALF,
                                                 COEF_FRAC_BITS));
            end else begin
              prod[ch][ky][kx] <= '0;
            end
          end
        end
      end
    end
  end

  // groups of up to eight taps per row
  always_comb begin
    int idx;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      for (int ky = 0; ky < K; ky++) begin
        for (int g = 0; g < NG; g++) begin
          grp_next[ch][ky][g] = '0;
          for (int i = 0; i < 8; i++) begin
            idx = (g * 8 + i < K) ? g * 8 + i : K - 1;
            if (g * 8 + i < K) begin
              grp_next[ch][ky][g] = grp_next[ch][ky][g] + SW'(prod[ch][ky][idx]);
            end
          end
        end
      end
    end
  end

  // row sums
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      for (int ky = 0; ky < K; ky++) begin
        rsum_next[ch][ky] = '0;
        for (int g = 0; g < NG; g++) begin
          rsum_next[ch][ky] = rsum_next[ch][ky] + grp[ch][ky][g];
        end
      end
    end
  end

  // groups of up to eight rows
  always_comb begin
    int idx;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      for (int g = 0; g < NG; g++) begin
        csum_next[ch][g] = '0;
        for (int i = 0; i < 8; i++) begin
          idx = (g * 8 + i < K) ? g * 8 + i : K - 1;
          if (g * 8 + i < K) begin
            csum_next[ch][g] = csum_next[ch][g] + rsum[ch][idx];
          end
        end
      end
    end
  end

  // final sum, truncate and clamp
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      total[ch] = '0;
      for (int g = 0; g < NG; g++) begin
        total[ch] = total[ch] + csum[ch][g];
      end
      if (total[ch][SW-1:COEF_FRAC_BITS] > RW'(255)) begin
        clamped[ch] = 8'hFF;
      end else begin
        clamped[ch] = total[ch][COEF_FRAC_BITS +: CH_W];
      end
    end
  end

  // tree registers and output register
  always_ff @(posedge clk) begin
    if (en) begin
      grp <= grp_next;
      rsum <= rsum_next;
      csum <= csum_next;
      out_red <= clamped[0];
      out_green <= clamped[1];
      out_blue <= clamped[2];
    end
  end

endmodule

`default_nettype wire

[rtl/gaussian_blur_15x15_rgb_core.sv]
// top level of the streaming 15x15 gaussian blur for rgb pixels
// throughput: one pixel per cycle unless in_stall, one result per cycle once the window
// is primed, unless out_stall; a completed window reaches out_valid through these stages:
//   (line store read, column assembly, queue, window shift, products, four adder levels)
// the first result of a frame follows 7*width+7 input transfers, flush items included
// reset: synchronous; clears counters, queue and valid bits, restores width 640 and height 480
`default_nettype none

module gaussian_blur_15x15_rgb_core import gbr_pkg::*; #(
  parameter int MAX_WIDTH = 2048,
  parameter int KERNEL_SIZE = 15,
  parameter int COEF_FRAC_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [CH_W-1:0]       in_red,
  input  wire logic [CH_W-1:0]       in_green,
  input  wire logic [CH_W-1:0]       in_blue,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [CH_W-1:0]            out_red,
  output logic [CH_W-1:0]            out_green,
  output logic [CH_W-1:0]            out_blue,
  output logic                       last_of_frame,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int COLW = KERNEL_SIZE * PIX_W;
  localparam int QW = $bits(gbr_flags_t) + 2 * KERNEL_SIZE + COLW;

  logic                     push;
  gbr_flags_t               push_flags;
  logic [KERNEL_SIZE-1:0]   push_rowv;
  logic [KERNEL_SIZE-1:0]   push_colv;
  logic [COLW-1:0]          push_column;
  logic [QUEUE_LEVEL_W-1:0] queue_level;
  logic                     head_valid;
  logic [QW-1:0]            head_data;
  logic                     pop;
  gbr_flags_t               head_flags;
  logic [KERNEL_SIZE-1:0]   head_rowv;
  logic [KERNEL_SIZE-1:0]   head_colv;
  logic [COLW-1:0]          head_column;

  // config writes are always accepted
  assign cfg_ready = 1'b1;

  // front: counters, line store, column assembly
  gbr_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .KERNEL_SIZE(KERNEL_SIZE)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_red     (in_red),
    .in_green   (in_green),
    .in_blue    (in_blue),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .queue_level(queue_level),
    .push       (push),
    .push_flags (push_flags),
    .push_rowv  (push_rowv),
    .push_colv  (push_colv),
    .push_column(push_column)
  );

  // queue between front and back
  gbr_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_flags, push_rowv, push_colv, push_column}),
    .pop       (pop),
    .head_valid(head_valid),
    .head_data (head_data),
    .level     (queue_level)
  );

  assign {head_flags, head_rowv, head_colv, head_column} = head_data;

  // back: window and convolution
  gbr_back #(
    .KERNEL_SIZE   (KERNEL_SIZE),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_flags   (head_flags),
    .head_rowv    (head_rowv),
    .head_colv    (head_colv),
    .head_column  (head_column),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .last_of_frame(last_of_frame)
  );

endmodule

`default_nettype wire

[tb/sv/gaussian_blur_15x15_rgb_core_tb.sv]
// self-checking testbench for the streaming 15x15 rgb gaussian blur core
`timescale 1ns / 1ps

module gaussian_blur_15x15_rgb_core_tb;
  import gbr_pkg::*;

  localparam int HALF = 7;
  localparam int KSZ = 15;
  localparam int DEPTH = 14;
  localparam int MAXW = 2048;
  localparam int FRAC = 16;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'hA5;

  typedef struct {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  typedef struct {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            last;
  } blur_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CH_W-1:0] in_red = '0, in_green = '0, in_blue = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CH_W-1:0] out_red, out_green, out_blue;
  logic last_of_frame;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  gaussian_blur_15x15_rgb_core dut (.*);

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [23:0] line_mem [0:MAXW-1][0:DEPTH-1];
  logic [23:0] win [0:KSZ-1][0:KSZ-1];
  longint unsigned kern [0:KSZ-1][0:KSZ-1];
  int unsigned col_pos, row_pos;
  logic [11:0] cur_width, cur_height;

  pixel_t pixel_queue[$];
  blur_t blurred_queue[$];
  int mismatches = 0;
  longint cycles = 0;
  bit no_idle = 1'b0;
  int hold_len = 0;
  bit in_xfer = 1'b0, out_xfer = 1'b0;
  int in_gap = 0, out_gap = 0;

  // q0.24 gaussian profile, sigma 2.5
  function automatic longint unsigned gauss_q24(int a);
    longint unsigned prof [0:15] = '{16777216, 15487322, 12182759, 8166348, 4664692,
                                     2270549, 941785, 332878, 100261, 25733, 5628,
                                     1049, 167, 23, 3, 0};
    return prof[a < 0 ? -a : a];
  endfunction

  function automatic void build_kernel();
    longint unsigned t;
    for (int y = 0; y < KSZ; y++)
      for (int x = 0; x < KSZ; x++) begin
        t = (gauss_q24(x - HALF) * gauss_q24(y - HALF) + (64'd1 << 23)) >> 24;
        kern[y][x] = (64'd427228 * t + (64'd1 << (47 - FRAC))) >> (48 - FRAC);
      end
  endfunction

  function automatic int unsigned eff_w();
    if (cur_width == 0) return 1;
    if (cur_width > MAXW) return MAXW;
    return cur_width;
  endfunction

  // one pixel into the blur window, pushes the blurred pixel it completes
  function automatic void blur_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int unsigned w, h, c;
    longint unsigned frame, pos, dly, q, xo, yo, ty, tx;
    logic [23:0] pix, v;
    longint unsigned acc [3];
    blur_t res;
    w = eff_w();
    h = (cur_height == 0) ? 1 : cur_height;
    c = col_pos;
    frame = longint'(w) * h;
    pix = '0;
    acc = '{0, 0, 0};
    if (c >= w) c = 0;
    pos = longint'(row_pos) * w + c;
    if (pos < frame) pix = {b, g, r};
    for (int ky = 0; ky < KSZ; ky++) begin
      for (int kx = 0; kx < KSZ - 1; kx++) win[ky][kx] = win[ky][kx + 1];
      win[ky][KSZ - 1] = (ky < DEPTH) ? line_mem[c][ky] : pix;
    end
    for (int ky = 0; ky < DEPTH - 1; ky++) line_mem[c][ky] = line_mem[c][ky + 1];
    line_mem[c][DEPTH - 1] = pix;
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1) & 32'h1FFF;
    end else begin
      col_pos = c + 1;
    end
    dly = longint'(HALF) * w + HALF;
    if (pos < dly) return;
    q = pos - dly;
    xo = q % w;
    yo = q / w;
    // zero padding: skip taps outside the frame
    for (int ky = 0; ky < KSZ; ky++) begin
      ty = yo + ky - HALF;
      if (yo + ky < HALF || ty >= h) continue;
      for (int kx = 0; kx < KSZ; kx++) begin
        tx = xo + kx - HALF;
        if (xo + kx < HALF || tx >= w) continue;
        v = win[ky][kx];
        for (int ch = 0; ch < 3; ch++) acc[ch] += kern[ky][kx] * v[8*ch +: 8];
      end
    end
    for (int ch = 0; ch < 3; ch++) acc[ch] = acc[ch] >> FRAC;
    res.red = acc[0] > 255 ? 8'd255 : acc[0][7:0];
    res.green = acc[1] > 255 ? 8'd255 : acc[1][7:0];
    res.blue = acc[2] > 255 ? 8'd255 : acc[2][7:0];
    res.last = (q + 1 >= frame);
    if (res.last) begin
      col_pos = 0;
      row_pos = 0;
    end
    blurred_queue.push_back(res);
  endfunction

  function automatic int draw_gap();
    if (no_idle) return 0;
    return $urandom_range(0, 6);
  endfunction

  // input driver: pixels change on the falling edge
  always @(negedge clk) begin
    if (!rst && !(in_valid && !in_xfer)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pixel_queue.size() > 0) begin
        pixel_t p;
        p = pixel_queue.pop_front();
        in_red <= p.red;
        in_green <= p.green;
        in_blue <= p.blue;
        in_valid <= 1'b1;
        in_gap <= draw_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output stall: long hold-off when requested, else random waits per transfer
  always @(negedge clk) begin
    if (hold_len > 0) begin
      hold_len = hold_len - 1;
      out_stall <= 1'b1;
    end else if (out_xfer) begin
      out_gap = draw_gap();
      out_stall <= (out_gap > 0);
    end else if (out_gap > 0) begin
      out_gap = out_gap - 1;
      out_stall <= (out_gap > 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: predict on input transfers, check output transfers
  always @(posedge clk) begin
    blur_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL gaussian_blur_15x15_rgb_core");
      $finish;
    end
    in_xfer = !rst && in_valid && !in_stall;
    out_xfer = !rst && out_valid && !out_stall;
    if (in_xfer) blur_pixel(in_red, in_green, in_blue);
    if (out_xfer) begin
      if (blurred_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output transfer at cycle %0d", cycles);
      end else begin
        e = blurred_queue.pop_front();
        if (e.red !== out_red || e.green !== out_green || e.blue !== out_blue ||
            e.last !== last_of_frame) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch cycle %0d: exp %0d %0d %0d last %0d, got %0d %0d %0d last %0d",
                     cycles, e.red, e.green, e.blue, e.last,
                     out_red, out_green, out_blue, last_of_frame);
        end
      end
    end
  end

  task automatic drain();
    while (pixel_queue.size() > 0 || in_valid || blurred_queue.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_IMAGE_WIDTH || idx == REG_IMAGE_HEIGHT) begin
      if (idx == REG_IMAGE_WIDTH) cur_width = val;
      else cur_height = val;
      col_pos = 0;
      row_pos = 0;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // fill: 0 random, 1 all ones, 2 all zero
  task automatic queue_pixels(int n, int fill);
    pixel_t p;
    for (int i = 0; i < n; i++) begin
      p.red = fill == 1 ? 8'hFF : fill == 2 ? 8'h00 : 8'($urandom);
      p.green = fill == 1 ? 8'hFF : fill == 2 ? 8'h00 : 8'($urandom);
      p.blue = fill == 1 ? 8'hFF : fill == 2 ? 8'h00 : 8'($urandom);
      pixel_queue.push_back(p);
    end
  endtask

  // frame plus flush pixels; returns pixel count
  task automatic run_frame(int w, int h, int fill, output int n);
    int ew, eh;
    write_reg(REG_IMAGE_WIDTH, 12'(w));
    write_reg(REG_IMAGE_HEIGHT, 12'(h));
    ew = (w == 0) ? 1 : (w > MAXW ? MAXW : w);
    eh = (h == 0) ? 1 : h;
    n = ew * eh + HALF * ew + HALF;
    queue_pixels(n, fill);
    drain();
  endtask

  initial begin
    int n, total, w, h;
    build_kernel();
    cur_width = RESET_IMAGE_WIDTH;
    cur_height = RESET_IMAGE_HEIGHT;
    col_pos = 0;
    row_pos = 0;
    total = 0;
    for (int y = 0; y < KSZ; y++)
      for (int x = 0; x < KSZ; x++) win[y][x] = '0;
    for (int c = 0; c < MAXW; c++)
      for (int d = 0; d < DEPTH; d++) line_mem[c][d] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: single pixel, saturated and dark frames, zero sizes
    run_frame(1, 1, 1, n);
    total += n;
    run_frame(2, 2, 1, n);
    total += n;
    run_frame(0, 0, 2, n);
    total += n;
    // partial frame continues across an out-of-range index write, which is ignored
    write_reg(REG_IMAGE_WIDTH, 12'd3);
    write_reg(REG_IMAGE_HEIGHT, 12'd3);
    queue_pixels(10, 1);
    drain();
    write_reg(REG_UNUSED, 12'hFFF);
    queue_pixels(21, 0);
    drain();
    total += 31;

    // extremes of width and height, cut short by the next register write
    no_idle = 1'b1;
    write_reg(REG_IMAGE_WIDTH, 12'hFFF);
    write_reg(REG_IMAGE_HEIGHT, 12'd1);
    queue_pixels(40, 0);
    drain();
    no_idle = 1'b0;
    write_reg(REG_IMAGE_WIDTH, 12'd1);
    write_reg(REG_IMAGE_HEIGHT, 12'hFFF);
    queue_pixels(100, 0);
    drain();
    total += 140;

    // receiver holds off while the sender keeps offering
    no_idle = 1'b1;
    hold_len = 600;
    run_frame(10, 10, 0, n);
    total += n;
    no_idle = 1'b0;

    // random frames, some burst, some cut short by a register write
    while (total < 1650) begin
      no_idle = ($urandom_range(0, 3) == 0);
      w = $urandom_range(1, 24);
      h = $urandom_range(1, 16);
      if ($urandom_range(0, 7) == 0) begin
        write_reg(REG_IMAGE_WIDTH, 12'(w));
        write_reg(REG_IMAGE_HEIGHT, 12'(h));
        n = $urandom_range(1, w * h + HALF * w + HALF);
        queue_pixels(n, 0);
        drain();
      end else begin
        run_frame(w, h, $urandom_range(0, 9) == 0 ? 1 : 0, n);
      end
      total += n;
    end

    drain();
    repeat (30) @(posedge clk);
    if (blurred_queue.size() > 0) mismatches++;
    if (mismatches == 0) begin
      $display("PASS gaussian_blur_15x15_rgb_core");
    end else begin
      $display("FAIL gaussian_blur_15x15_rgb_core");
    end
    $finish;
  end

endmodule
